/* sv/tspr_pkg.sv */
// Shared types and constants for the tile and sprite pixel renderer.
package tspr_pkg;

  localparam int SPRITE_COUNT  = 40;
  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 144;
  localparam int VIDEO_BYTES   = 8192;

  localparam int OAM_BYTES = SPRITE_COUNT * 4;
  localparam int VRAM_AW   = $clog2(VIDEO_BYTES);
  localparam int OAM_AW    = $clog2(OAM_BYTES);
  localparam int SPR_IDX_W = (OAM_AW > 2) ? OAM_AW - 2 : 1;

  // Item kinds; the fourth code is unused and ignored
  typedef enum logic [1:0] {
    KIND_VRAM_WR = 2'd0,
    KIND_OAM_WR  = 2'd1,
    KIND_RENDER  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [12:0] address;
    logic [7:0]  data;
    logic [7:0]  line;
    logic [7:0]  column;
  } in_item_t;

  typedef struct packed {
    logic [1:0] pixel;
    logic       from_sprite;
  } out_item_t;

endpackage

/* sv/tspr_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module tspr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/tile_sprite_pixel_renderer.sv */
// Top level: tile and sprite pixel renderer with video memory and sprite table.
//
// Pulse start with an item while busy is low. Write items (video memory or
// sprite table) are stored at the accepting edge and leave busy low; items of
// the unused kind and renders off screen are dropped. A render raises busy
// and, when finished, drives result for exactly one cycle with done high; the
// receiver must take it then. A render reads the background and, with sprites
// enabled, then walks every entry of the sprite table; the sprite walk sets
// the length of a render. Each entry takes four reads of the single read port
// of the sprite table, and a covering sprite adds two reads of the video
// memory for its bit planes. The background needs three dependent video
// memory reads (map entry, low plane, high plane). Configuration registers
// are written over the APB port; the user must write them only while idle,
// as the block itself does not enforce it.
module tile_sprite_pixel_renderer
  import tspr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        start,
  input  in_item_t    request,
  output logic        busy,
  // result channel
  output logic        done,
  output out_item_t   result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    REG_CONTROL  = 2'd0,
    REG_SCROLL_X = 2'd1,
    REG_SCROLL_Y = 2'd2,
    REG_PALETTE  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MAP, S_TILE, S_BGLO, S_BGHI,
    S_SX, S_ST, S_SA, S_SCHK, S_SLO, S_SHI
  } state_t;

  localparam logic [SPR_IDX_W-1:0] LAST_IDX = SPR_IDX_W'(SPRITE_COUNT - 1);

  // configuration registers
  logic [7:0] lcd_control;
  logic [7:0] scroll_x;
  logic [7:0] scroll_y;
  logic [7:0] bg_palette;

  // sequencer state
  state_t                 state;
  logic [7:0]             line_r;
  logic [7:0]             column_r;
  logic [SPR_IDX_W-1:0]   idx;
  logic [7:0]             sy;
  logic [7:0]             sx;
  logic [7:0]             stile;
  logic [VRAM_AW-1:0]     row_addr;
  logic [2:0]             bit_sel;
  logic [7:0]             plane_lo;

  // memory ports
  logic               accept;
  logic               vram_we;
  logic               vram_re;
  logic [VRAM_AW-1:0] vram_raddr;
  logic [7:0]         vram_rdata;
  logic               oam_we;
  logic               oam_re;
  logic [OAM_AW-1:0]  oam_raddr;
  logic [7:0]         oam_rdata;

  // datapath
  logic [7:0]           bx;
  logic [7:0]           by;
  logic [VRAM_AW-1:0]   map_addr;
  logic [VRAM_AW-1:0]   bg_row;
  logic [9:0]           dy;
  logic [9:0]           dx;
  logic                 spr_hit;
  logic [2:0]           row3;
  logic [2:0]           col3;
  logic [VRAM_AW-1:0]   spr_row;
  logic [1:0]           ci;
  logic [7:0]           pal_shift;
  logic [1:0]           shade;
  logic [SPR_IDX_W-1:0] idx_next;
  logic                 onscreen;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control <= 8'd145;
      scroll_x    <= 8'd0;
      scroll_y    <= 8'd0;
      bg_palette  <= 8'd252;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_CONTROL:  lcd_control <= pwdata[7:0];
        REG_SCROLL_X: scroll_x    <= pwdata[7:0];
        REG_SCROLL_Y: scroll_y    <= pwdata[7:0];
        REG_PALETTE:  bg_palette  <= pwdata[7:0];
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_CONTROL:  prdata = {24'd0, lcd_control};
      REG_SCROLL_X: prdata = {24'd0, scroll_x};
      REG_SCROLL_Y: prdata = {24'd0, scroll_y};
      REG_PALETTE:  prdata = {24'd0, bg_palette};
    endcase
  end

  // write items go straight into the stores at acceptance
  assign vram_we = accept && (request.kind == KIND_VRAM_WR);
  assign oam_we  = accept && (request.kind == KIND_OAM_WR) &&
                   (request.address < 13'(OAM_BYTES));
  assign onscreen = ({1'b0, request.line} < 9'(SCREEN_HEIGHT)) &&
                    ({1'b0, request.column} < 9'(SCREEN_WIDTH));

  tspr_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (request.address[VRAM_AW-1:0]),
    .wdata (request.data),
    .re    (vram_re),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  tspr_ram #(.WIDTH(8), .DEPTH(OAM_BYTES)) u_oam (
    .clk   (clk),
    .we    (oam_we),
    .waddr (request.address[OAM_AW-1:0]),
    .wdata (request.data),
    .re    (oam_re),
    .raddr (oam_raddr),
    .rdata (oam_rdata)
  );

  // background address math
  assign bx       = column_r + scroll_x;
  assign by       = line_r + scroll_y;
  assign map_addr = {2'b11, lcd_control[3], by[7:3], bx[7:3]};
  // signed mode puts tiles 0..127 at 0x9000 and 128..255 at 0x8800
  assign bg_row   = {~lcd_control[4] & ~vram_rdata[7], vram_rdata, by[2:0], 1'b0};

  // sprite cover test and flipped row/column
  assign dy      = {2'b00, line_r} + 10'd16 - {2'b00, sy};
  assign dx      = {2'b00, column_r} + 10'd8 - {2'b00, sx};
  assign spr_hit = !dy[9] && (dy[8:3] == 6'd0) && !dx[9] && (dx[8:3] == 6'd0);
  assign row3    = dy[2:0] ^ {3{oam_rdata[6]}};
  assign col3    = dx[2:0] ^ {3{oam_rdata[5]}};
  assign spr_row = {1'b0, stile, row3, 1'b0};

  // bit plane decode: leftmost pixel is bit 7
  assign ci        = {vram_rdata[~bit_sel], plane_lo[~bit_sel]};
  assign pal_shift = bg_palette >> {ci, 1'b0};
  assign shade     = pal_shift[1:0];
  assign idx_next  = idx + 1'b1;

  // memory read addresses per sequencer step
  always_comb begin
    vram_re    = 1'b0;
    vram_raddr = map_addr;
    oam_re     = 1'b0;
    oam_raddr  = OAM_AW'({idx_next, 2'b00});
    unique case (state)
      S_MAP: begin
        vram_re    = 1'b1;
        vram_raddr = map_addr;
      end
      S_TILE: begin
        vram_re    = 1'b1;
        vram_raddr = bg_row;
      end
      S_BGLO, S_SLO: begin
        vram_re    = 1'b1;
        vram_raddr = {row_addr[VRAM_AW-1:1], 1'b1};
      end
      S_BGHI: begin
        oam_re    = 1'b1;
        oam_raddr = '0;
      end
      S_SX: begin
        oam_re    = 1'b1;
        oam_raddr = OAM_AW'({idx, 2'b01});
      end
      S_ST: begin
        oam_re    = 1'b1;
        oam_raddr = OAM_AW'({idx, 2'b10});
      end
      S_SA: begin
        oam_re    = 1'b1;
        oam_raddr = OAM_AW'({idx, 2'b11});
      end
      S_SCHK: begin
        vram_re    = spr_hit;
        vram_raddr = spr_row;
        oam_re     = !spr_hit && (idx != LAST_IDX);
      end
      S_SHI: begin
        oam_re = (idx != LAST_IDX);
      end
      default: begin
      end
    endcase
  end

  // render sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && (request.kind == KIND_RENDER) && onscreen) begin
            line_r   <= request.line;
            column_r <= request.column;
            state    <= S_MAP;
          end
        end
        S_MAP: state <= S_TILE;
        S_TILE: begin
          row_addr <= bg_row;
          bit_sel  <= bx[2:0];
          state    <= S_BGLO;
        end
        S_BGLO: begin
          plane_lo <= vram_rdata;
          state    <= S_BGHI;
        end
        S_BGHI: begin
          result.pixel       <= shade;
          result.from_sprite <= 1'b0;
          idx                <= '0;
          if (lcd_control[1]) begin
            state <= S_SX;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SX: begin
          sy    <= oam_rdata;
          state <= S_ST;
        end
        S_ST: begin
          sx    <= oam_rdata;
          state <= S_SA;
        end
        S_SA: begin
          stile <= oam_rdata;
          state <= S_SCHK;
        end
        S_SCHK: begin
          if (spr_hit) begin
            row_addr <= spr_row;
            bit_sel  <= col3;
            state    <= S_SLO;
          end else if (idx == LAST_IDX) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx   <= idx_next;
            state <= S_SX;
          end
        end
        S_SLO: begin
          plane_lo <= vram_rdata;
          state    <= S_SHI;
        end
        S_SHI: begin
          // opaque pixel of a later sprite overrides earlier ones
          if (ci != 2'd0) begin
            result.pixel       <= ci;
            result.from_sprite <= 1'b1;
          end
          if (idx == LAST_IDX) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx   <= idx_next;
            state <= S_SX;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result only ends a render that was running
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a render in progress");

  // busy only rises after a start pulse
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an item");

  // an on-screen render always starts the sequencer
  a_render_starts: assert property (@(posedge clk) disable iff (rst)
    accept && (request.kind == KIND_RENDER) && onscreen |=> busy)
    else $error("render item was not started");

endmodule
